// ----- rtl/bbdd_pkg.sv -----
`timescale 1ns / 1ps

package bbdd_pkg;

  // Pipeline length, input to output register
  localparam int PIPE_DEPTH = 7;

  // Internal widths
  localparam int DX_W  = 22;  // scaled centre delta, Q.12
  localparam int DW_W  = 18;  // clipped size delta, Q.12
  localparam int SUM_W = 25;  // x1 + x2, Q.4
  localparam int PW_W  = 26;  // anchor size, Q.4
  localparam int PD_W  = 48;  // size * centre delta
  localparam int G_W   = 53;  // centre / half size, Q.20
  localparam int TAB_W = 17;  // exp table entry, Q.16
  localparam int MAG_W = 43;  // |size| * table entry
  localparam int K_W   = 9;   // integer part of d*log2(e)

  // Fixed-point constants
  localparam logic signed [35:0] LOG2E_Q16 = 36'sd94548;
  localparam logic [63:0]        LN2_Q30   = 64'd744261118;
  localparam logic [51:0]        GW_LIMIT  = 52'h8000000000000;
  localparam logic signed [54:0] HALF_Q20  = 55'sd524288;

  // Register map
  localparam logic [2:0] REG_MEAN_OFFSETS  = 3'd0;
  localparam logic [2:0] REG_STD_SCALES    = 3'd1;
  localparam logic [2:0] REG_MAX_LOG_RATIO = 3'd2;
  localparam logic [2:0] REG_MAX_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_MAX_WIDTH     = 3'd4;

  typedef struct packed {
    logic signed [23:0] anchor_x1;
    logic signed [23:0] anchor_y1;
    logic signed [23:0] anchor_x2;
    logic signed [23:0] anchor_y2;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
  } bbdd_in_t;

  typedef struct packed {
    logic [19:0] box_x1;
    logic [19:0] box_y1;
    logic [19:0] box_x2;
    logic [19:0] box_y2;
  } bbdd_out_t;

  typedef struct packed {
    logic [63:0] mean_offsets;
    logic [63:0] std_scales;
    logic [15:0] max_log_ratio;
    logic [15:0] max_height;
    logic [15:0] max_width;
  } bbdd_cfg_t;

endpackage

// ----- rtl/bbdd_delta_scale.sv -----
`timescale 1ns / 1ps

module bbdd_delta_scale import bbdd_pkg::*; (
  input  logic                   clk,
  input  logic [1:0]             stg_ld,
  input  bbdd_in_t               in_data,
  input  bbdd_cfg_t              cfg,
  output logic signed [DX_W-1:0] dx,
  output logic signed [DX_W-1:0] dy,
  output logic signed [DW_W-1:0] dw,
  output logic signed [DW_W-1:0] dh
);

  logic signed [15:0] raw [4];
  logic signed [31:0] prod_nxt [4];
  logic signed [31:0] prod_r [4];
  logic signed [DX_W-1:0] d_full [4];
  logic signed [DW_W-1:0] dw_nxt, dh_nxt;
  logic signed [DX_W-1:0] dx_r, dy_r;
  logic signed [DW_W-1:0] dw_r, dh_r;
  logic signed [DX_W-1:0] lim;

  assign raw[0] = in_data.delta_x;
  assign raw[1] = in_data.delta_y;
  assign raw[2] = in_data.delta_w;
  assign raw[3] = in_data.delta_h;

  // Lane math: raw * std, then round to Q.12 and add the mean
  for (genvar n = 0; n < 4; n++) begin : g_lane
    logic signed [15:0] std_l, mean_l;
    logic signed [32:0] rsum;
    logic signed [20:0] rnd;
    assign std_l    = $signed(cfg.std_scales[16*n +: 16]);
    assign mean_l   = $signed(cfg.mean_offsets[16*n +: 16]);
    assign prod_nxt[n] = raw[n] * std_l;
    assign rsum     = 33'(prod_r[n]) + 33'sd2048;
    assign rnd      = 21'(rsum >>> 12);
    assign d_full[n] = DX_W'(rnd) + DX_W'(mean_l);
  end

  // Clip the size deltas to +/- max_log_ratio
  assign lim = DX_W'($signed({2'b00, cfg.max_log_ratio}));

  function automatic logic signed [DW_W-1:0] clip(input logic signed [DX_W-1:0] d,
                                                  input logic signed [DX_W-1:0] m);
    logic signed [DX_W-1:0] r;
    if (d > m) begin
      r = m;
    end else if (d < -m) begin
      r = -m;
    end else begin
      r = d;
    end
    return DW_W'(r);
  endfunction

  assign dw_nxt = clip(d_full[2], lim);
  assign dh_nxt = clip(d_full[3], lim);

  always_ff @(posedge clk) begin
    if (stg_ld[0]) begin
      for (int n = 0; n < 4; n++) prod_r[n] <= prod_nxt[n];
    end
    if (stg_ld[1]) begin
      dx_r <= d_full[0];
      dy_r <= d_full[1];
      dw_r <= dw_nxt;
      dh_r <= dh_nxt;
    end
  end

  assign dx = dx_r;
  assign dy = dy_r;
  assign dw = dw_r;
  assign dh = dh_r;

endmodule

// ----- rtl/bbdd_exp_scale.sv -----
`timescale 1ns / 1ps

module bbdd_exp_scale import bbdd_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                   clk,
  input  logic [3:0]             stg_ld,
  input  logic signed [DW_W-1:0] d,
  input  logic signed [PW_W-1:0] p,
  output logic signed [G_W-1:0]  half
);

  localparam int IW   = $clog2(EXP_TABLE_DEPTH);
  localparam int FP_W = 12 + $clog2(EXP_TABLE_DEPTH + 1);

  // Taylor term divide, literal divisors only
  function automatic logic [63:0] div_n(input logic [63:0] v, input int n);
    logic [63:0] r;
    case (n)
      1:       r = v;
      2:       r = v / 64'd2;
      3:       r = v / 64'd3;
      4:       r = v / 64'd4;
      5:       r = v / 64'd5;
      6:       r = v / 64'd6;
      7:       r = v / 64'd7;
      8:       r = v / 64'd8;
      9:       r = v / 64'd9;
      10:      r = v / 64'd10;
      11:      r = v / 64'd11;
      12:      r = v / 64'd12;
      13:      r = v / 64'd13;
      14:      r = v / 64'd14;
      15:      r = v / 64'd15;
      16:      r = v / 64'd16;
      default: r = v;
    endcase
    return r;
  endfunction

  // 2^(i/depth) in Q.16 from a 16-term series in Q.30
  function automatic logic [TAB_W-1:0] tab_entry(input int i);
    logic [63:0] x, sum, term;
    x = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
    sum  = 64'd1 << 30;
    term = sum;
    for (int n = 1; n <= 16; n++) begin
      term = div_n((term * x) >> 30, n);
      sum  = sum + term;
    end
    return TAB_W'((sum + 64'd8192) >> 14);
  endfunction

  logic [TAB_W-1:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    assign exp_tab[g] = tab_entry(g);
  end

  // E1: d * log2(e)
  logic signed [35:0]     tp_nxt, tp_r;
  logic signed [PW_W-1:0] p1_r;
  assign tp_nxt = 36'(d) * LOG2E_Q16;

  // E2: split into integer and fraction, table lookup
  logic signed [36:0]      tsum;
  logic signed [20:0]      t;
  logic signed [K_W-1:0]   k_nxt, k2_r;
  logic [11:0]             f;
  logic [FP_W-1:0]         fprod;
  logic [IW-1:0]           idx;
  logic [TAB_W-1:0]        tab_r;
  logic signed [PW_W-1:0]  p2_r;
  assign tsum  = 37'(tp_r) + 37'sd32768;
  assign t     = 21'(tsum >>> 16);
  assign k_nxt = K_W'(t >>> 12);
  assign f     = t[11:0];
  assign fprod = FP_W'(f) * FP_W'(EXP_TABLE_DEPTH);
  assign idx   = fprod[12 +: IW];

  // E3: |size| * table entry
  logic [PW_W-1:0]       pabs;
  logic [MAG_W-1:0]      mag_nxt, mag_r;
  logic                  neg_r;
  logic signed [K_W-1:0] k3_r;
  assign pabs    = p2_r[PW_W-1] ? PW_W'(-p2_r) : PW_W'(p2_r);
  assign mag_nxt = MAG_W'(pabs) * MAG_W'(tab_r);

  // E4: scale by 2^k with saturation, apply sign, halve
  logic [66:0]           shl;
  logic [51:0]           gw_mag;
  logic signed [G_W-1:0] gw, half_nxt, half_r;
  logic [4:0]            rsh;
  assign shl = 67'(mag_r) << k3_r[4:0];
  assign rsh = 5'(-k3_r);

  always_comb begin
    if (k3_r[K_W-1]) begin
      gw_mag = 52'(mag_r >> rsh);
    end else if (shl > 67'(GW_LIMIT)) begin
      gw_mag = GW_LIMIT;
    end else begin
      gw_mag = shl[51:0];
    end
    gw       = neg_r ? -$signed(G_W'(gw_mag)) : $signed(G_W'(gw_mag));
    half_nxt = gw >>> 1;
  end

  always_ff @(posedge clk) begin
    if (stg_ld[0]) begin
      tp_r <= tp_nxt;
      p1_r <= p;
    end
    if (stg_ld[1]) begin
      k2_r  <= k_nxt;
      tab_r <= exp_tab[idx];
      p2_r  <= p1_r;
    end
    if (stg_ld[2]) begin
      mag_r <= mag_nxt;
      neg_r <= p2_r[PW_W-1];
      k3_r  <= k2_r;
    end
    if (stg_ld[3]) begin
      half_r <= half_nxt;
    end
  end

  assign half = half_r;

endmodule

// ----- rtl/bbdd_corner.sv -----
`timescale 1ns / 1ps

module bbdd_corner import bbdd_pkg::*; (
  input  logic                  clk,
  input  logic                  stg_ld,
  input  logic signed [G_W-1:0] gx,
  input  logic signed [G_W-1:0] gy,
  input  logic signed [G_W-1:0] hw,
  input  logic signed [G_W-1:0] hh,
  input  logic [15:0]           max_width,
  input  logic [15:0]           max_height,
  output bbdd_out_t             out_data
);

  // Round Q.20 to Q.4 and clamp to [0, 16*max]
  function automatic logic [19:0] to_out(input logic signed [54:0] v,
                                         input logic [15:0] maxpix);
    logic signed [54:0] r;
    logic signed [38:0] q;
    logic [19:0]        hi;
    logic [19:0]        res;
    r  = v + 55'sd32768;
    q  = 39'(r >>> 16);
    hi = {maxpix, 4'b0000};
    if (q < 0) begin
      res = '0;
    end else if (q > $signed({19'b0, hi})) begin
      res = hi;
    end else begin
      res = q[19:0];
    end
    return res;
  endfunction

  bbdd_out_t out_nxt, out_r;

  always_comb begin
    out_nxt.box_x1 = to_out(55'(gx) - 55'(hw) + HALF_Q20, max_width);
    out_nxt.box_y1 = to_out(55'(gy) - 55'(hh) + HALF_Q20, max_height);
    out_nxt.box_x2 = to_out(55'(gx) + 55'(hw) - HALF_Q20, max_width);
    out_nxt.box_y2 = to_out(55'(gy) + 55'(hh) - HALF_Q20, max_height);
  end

  always_ff @(posedge clk) begin
    if (stg_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/bounding_box_delta_decode.sv -----
`timescale 1ns / 1ps

// Box delta decoder: takes one anchor box and four regression deltas per
// request and returns the decoded, image-clamped box corners. Fully pipelined:
// one box per cycle sustained while out_stall is low. There are seven register
// stages; the first loads at the edge that accepts the request, and out_* is
// driven from the last. The seven stages are delta scaling (multiply, then
// round/mean/clip), exp argument multiply, table lookup with the centre sum,
// size-times-table multiply, power-of-two scaling, and corner rounding and
// clamping. Each stage holds its own valid bit and fills when empty, so
// bubbles close up and in_stall rises only when all seven stages are full
// and out_stall is high. Configuration writes are always ready and must only
// be issued while no request is in flight.

module bounding_box_delta_decode import bbdd_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bbdd_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output bbdd_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers
  bbdd_cfg_t cfg_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_offsets  <= 64'h0;
      cfg_r.std_scales    <= 64'h1000100010001000;
      cfg_r.max_log_ratio <= 16'd16937;
      cfg_r.max_height    <= 16'd768;
      cfg_r.max_width     <= 16'd1280;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MEAN_OFFSETS:  cfg_r.mean_offsets  <= cfg_data;
        REG_STD_SCALES:    cfg_r.std_scales    <= cfg_data;
        REG_MAX_LOG_RATIO: cfg_r.max_log_ratio <= cfg_data[15:0];
        REG_MAX_HEIGHT:    cfg_r.max_height    <= cfg_data[15:0];
        REG_MAX_WIDTH:     cfg_r.max_width     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when empty or when its content moves on
  logic [PIPE_DEPTH:1] ld, v_r, v_nxt;

  always_comb begin
    ld[PIPE_DEPTH] = !v_r[PIPE_DEPTH] || !out_stall;
    for (int s = PIPE_DEPTH - 1; s >= 1; s--) begin
      ld[s] = !v_r[s] || ld[s+1];
    end
    v_nxt[1] = ld[1] ? in_valid : v_r[1];
    for (int s = 2; s <= PIPE_DEPTH; s++) begin
      v_nxt[s] = ld[s] ? v_r[s-1] : v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !ld[1];
  assign out_valid = v_r[PIPE_DEPTH];

  // Delta scaling, stages 1-2
  logic signed [DX_W-1:0] dx, dy;
  logic signed [DW_W-1:0] dw, dh;

  bbdd_delta_scale u_delta (
    .clk     (clk),
    .stg_ld  (ld[2:1]),
    .in_data (in_data),
    .cfg     (cfg_r),
    .dx      (dx),
    .dy      (dy),
    .dw      (dw),
    .dh      (dh)
  );

  // Anchor geometry and centre path
  logic signed [SUM_W-1:0] sx_nxt, sy_nxt, sx1_r, sy1_r, sx2_r, sy2_r, sx3_r, sy3_r;
  logic signed [PW_W-1:0]  pw_nxt, ph_nxt, pw1_r, ph1_r, pw2_r, ph2_r;
  logic signed [PD_W-1:0]  pwdx_nxt, phdy_nxt, pwdx_r, phdy_r;
  logic signed [G_W-1:0]   gx_nxt, gy_nxt, gx4_r, gy4_r, gx5_r, gy5_r, gx6_r, gy6_r;

  assign sx_nxt   = SUM_W'(in_data.anchor_x1) + SUM_W'(in_data.anchor_x2);
  assign sy_nxt   = SUM_W'(in_data.anchor_y1) + SUM_W'(in_data.anchor_y2);
  assign pw_nxt   = PW_W'(in_data.anchor_x2) - PW_W'(in_data.anchor_x1) + 26'sd16;
  assign ph_nxt   = PW_W'(in_data.anchor_y2) - PW_W'(in_data.anchor_y1) + 26'sd16;
  assign pwdx_nxt = PD_W'(pw2_r) * PD_W'(dx);
  assign phdy_nxt = PD_W'(ph2_r) * PD_W'(dy);
  assign gx_nxt   = (G_W'(sx3_r) <<< 15) + (G_W'(pwdx_r) <<< 4);
  assign gy_nxt   = (G_W'(sy3_r) <<< 15) + (G_W'(phdy_r) <<< 4);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sx1_r <= sx_nxt;
      sy1_r <= sy_nxt;
      pw1_r <= pw_nxt;
      ph1_r <= ph_nxt;
    end
    if (ld[2]) begin
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      pw2_r <= pw1_r;
      ph2_r <= ph1_r;
    end
    if (ld[3]) begin
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      pwdx_r <= pwdx_nxt;
      phdy_r <= phdy_nxt;
    end
    if (ld[4]) begin
      gx4_r <= gx_nxt;
      gy4_r <= gy_nxt;
    end
    if (ld[5]) begin
      gx5_r <= gx4_r;
      gy5_r <= gy4_r;
    end
    if (ld[6]) begin
      gx6_r <= gx5_r;
      gy6_r <= gy5_r;
    end
  end

  // Size path through exp, stages 3-6
  logic signed [G_W-1:0] hw, hh;

  bbdd_exp_scale #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_w (
    .clk    (clk),
    .stg_ld (ld[6:3]),
    .d      (dw),
    .p      (pw2_r),
    .half   (hw)
  );

  bbdd_exp_scale #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_h (
    .clk    (clk),
    .stg_ld (ld[6:3]),
    .d      (dh),
    .p      (ph2_r),
    .half   (hh)
  );

  // Corners and output register, stage 7
  bbdd_corner u_corner (
    .clk        (clk),
    .stg_ld     (ld[PIPE_DEPTH]),
    .gx         (gx6_r),
    .gy         (gy6_r),
    .hw         (hw),
    .hh         (hh),
    .max_width  (cfg_r.max_width),
    .max_height (cfg_r.max_height),
    .out_data   (out_data)
  );

  // Back-pressure only when every stage is occupied and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r && out_stall))
    else $error("in_stall with a free stage");

  // A draining output always frees room for a new request
  a_drain_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |-> !in_stall)
    else $error("stall while output drains");

  // Occupancy grows by one on an accept without a delivery
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !(out_valid && !out_stall)) |=>
      ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("request lost in pipeline");

endmodule
